// ===== rtl/core/amlns_pkg.sv =====
// amlns_pkg: shared constants and character-class helpers for the AML name string parser
// no dependencies; used by aml_name_string_parser_core, the checker and the testbench
`default_nettype none

package amlns_pkg;

    localparam logic [7:0] ROOT_CH   = 8'h5C;
    localparam logic [7:0] PARENT_CH = 8'h5E;
    localparam logic [7:0] DUAL_PFX  = 8'h2E;
    localparam logic [7:0] MULTI_PFX = 8'h2F;
    localparam logic [7:0] NULL_NM   = 8'h00;

    // index of the last char inside a four-byte name segment
    localparam logic [1:0] SEG_TAIL  = 2'd3;

    localparam logic [8:0]  HDR_MAX = 9'd511;
    localparam logic [10:0] CNT_MAX = 11'd2047;
    localparam logic [7:0]  DEPTH_MAX = 8'd255;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    function automatic logic is_lead(input logic [7:0] b);
        is_lead = ((b >= 8'h41) && (b <= 8'h5A)) || (b == 8'h5F);
    endfunction

    function automatic logic is_namech(input logic [7:0] b);
        is_namech = is_lead(b) || ((b >= 8'h30) && (b <= 8'h39));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aml_name_string_parser_core.sv =====
// aml_name_string_parser_core: byte-serial AML NameString recognizer with valid/ready channels
// depends on amlns_pkg for character codes and class helpers
`default_nettype none

// Takes one AML byte per request on s_* and emits one result on m_* when a NameString
// completes (status 0) or at its first invalid byte (status 1), then returns to idle.
// Throughput is one byte per clock while no result waits on m_ready: a byte is captured
// in the input register, the parse state updates as it moves on, and any result lands in
// the output register. Both sides stall only on each other: a byte is held while a
// finished result waits on m_ready.
module aml_name_string_parser_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_parse_status,
    output logic             m_rooted,
    output logic [7:0]       m_parent_depth,
    output logic [7:0]       m_segment_count,
    output logic [8:0]       m_header_length,
    output logic [10:0]      m_total_length
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PARENTS = 3'd1,
        PH_PATH    = 3'd2,
        PH_COUNT   = 3'd3,
        PH_SEG     = 3'd4
    } phase_t;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;

    // parse state
    phase_t      phase_reg, phase_next;
    logic        root_reg, root_next;
    logic [7:0]  depth_reg, depth_next;
    logic [7:0]  segs_total_reg, segs_total_next;
    logic [7:0]  segs_left_reg, segs_left_next;
    logic [1:0]  cidx_reg, cidx_next;
    logic [8:0]  hdr_reg, hdr_next;
    logic [10:0] cnt_reg, cnt_next;

    // output register
    logic        m_valid_reg;
    logic        status_reg;
    logic        rooted_reg;
    logic [7:0]  depth_out_reg;
    logic [7:0]  segs_out_reg;
    logic [8:0]  hdr_out_reg;
    logic [10:0] cnt_out_reg;

    logic        advance;
    logic        fin;
    logic        fin_status;
    logic [8:0]  hdr_inc;
    logic [7:0]  b;
    logic        seg_ok;
    logic [7:0]  segs_left_dec;

    assign advance = in_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign b       = in_byte_reg;
    assign hdr_inc = (hdr_reg < amlns_pkg::HDR_MAX) ? hdr_reg + 9'd1 : hdr_reg;
    assign seg_ok  = (cidx_reg == 2'd0) ? amlns_pkg::is_lead(b) : amlns_pkg::is_namech(b);
    assign segs_left_dec = (segs_left_reg != 8'd0) ? segs_left_reg - 8'd1 : segs_left_reg;

    always_comb begin
        phase_next      = phase_reg;
        root_next       = root_reg;
        depth_next      = depth_reg;
        segs_total_next = segs_total_reg;
        segs_left_next  = segs_left_reg;
        cidx_next       = cidx_reg;
        hdr_next        = hdr_reg;
        cnt_next        = (cnt_reg < amlns_pkg::CNT_MAX) ? cnt_reg + 11'd1 : cnt_reg;
        fin             = 1'b0;
        fin_status      = amlns_pkg::STATUS_OK;

        unique case (phase_reg)
            PH_IDLE, PH_PARENTS, PH_PATH: begin
                if ((phase_reg == PH_IDLE) && (b == amlns_pkg::ROOT_CH)) begin
                    root_next  = 1'b1;
                    hdr_next   = hdr_inc;
                    phase_next = PH_PATH;
                end else if ((phase_reg != PH_PATH) && (b == amlns_pkg::PARENT_CH)) begin
                    if (phase_reg == PH_IDLE) begin
                        depth_next = 8'd1;
                    end else if (depth_reg < amlns_pkg::DEPTH_MAX) begin
                        depth_next = depth_reg + 8'd1;
                    end
                    hdr_next   = hdr_inc;
                    phase_next = PH_PARENTS;
                end else if (amlns_pkg::is_lead(b)) begin
                    // single segment, lead char already consumed
                    segs_total_next = 8'd1;
                    segs_left_next  = 8'd1;
                    cidx_next       = 2'd1;
                    phase_next      = PH_SEG;
                end else if (b == amlns_pkg::DUAL_PFX) begin
                    hdr_next        = hdr_inc;
                    segs_total_next = 8'd2;
                    segs_left_next  = 8'd2;
                    cidx_next       = 2'd0;
                    phase_next      = PH_SEG;
                end else if (b == amlns_pkg::MULTI_PFX) begin
                    hdr_next   = hdr_inc;
                    phase_next = PH_COUNT;
                end else if (b == amlns_pkg::NULL_NM) begin
                    hdr_next = hdr_inc;
                    fin      = 1'b1;
                end else begin
                    fin        = 1'b1;
                    fin_status = amlns_pkg::STATUS_BAD;
                end
            end
            PH_COUNT: begin
                hdr_next        = hdr_inc;
                segs_total_next = b;
                segs_left_next  = b;
                cidx_next       = 2'd0;
                if (b == 8'd0) begin
                    fin = 1'b1;
                end else begin
                    phase_next = PH_SEG;
                end
            end
            PH_SEG: begin
                if (!seg_ok) begin
                    fin        = 1'b1;
                    fin_status = amlns_pkg::STATUS_BAD;
                end else if (cidx_reg == amlns_pkg::SEG_TAIL) begin
                    cidx_next      = 2'd0;
                    segs_left_next = segs_left_dec;
                    if (segs_left_dec == 8'd0) begin
                        fin = 1'b1;
                    end
                end else begin
                    cidx_next = cidx_reg + 2'd1;
                end
            end
            default: begin
                phase_next      = PH_IDLE;
                root_next       = 1'b0;
                depth_next      = 8'd0;
                segs_total_next = 8'd0;
                segs_left_next  = 8'd0;
                cidx_next       = 2'd0;
                hdr_next        = 9'd0;
                cnt_next        = 11'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            phase_reg      <= PH_IDLE;
            root_reg       <= 1'b0;
            depth_reg      <= 8'd0;
            segs_total_reg <= 8'd0;
            segs_left_reg  <= 8'd0;
            cidx_reg       <= 2'd0;
            hdr_reg        <= 9'd0;
            cnt_reg        <= 11'd0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance && fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance) begin
                if (fin) begin
                    // result carries values reached with this byte, then back to idle
                    phase_reg      <= PH_IDLE;
                    root_reg       <= 1'b0;
                    depth_reg      <= 8'd0;
                    segs_total_reg <= 8'd0;
                    segs_left_reg  <= 8'd0;
                    cidx_reg       <= 2'd0;
                    hdr_reg        <= 9'd0;
                    cnt_reg        <= 11'd0;
                end else begin
                    phase_reg      <= phase_next;
                    root_reg       <= root_next;
                    depth_reg      <= depth_next;
                    segs_total_reg <= segs_total_next;
                    segs_left_reg  <= segs_left_next;
                    cidx_reg       <= cidx_next;
                    hdr_reg        <= hdr_next;
                    cnt_reg        <= cnt_next;
                end
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
        end
        if (advance && fin) begin
            status_reg    <= fin_status;
            rooted_reg    <= root_next;
            depth_out_reg <= depth_next;
            segs_out_reg  <= segs_total_next;
            hdr_out_reg   <= hdr_next;
            cnt_out_reg   <= cnt_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_parse_status  = status_reg;
    assign m_rooted        = rooted_reg;
    assign m_parent_depth  = depth_out_reg;
    assign m_segment_count = segs_out_reg;
    assign m_header_length = hdr_out_reg;
    assign m_total_length  = cnt_out_reg;

    // a stalled result freezes the parse state
    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(cnt_reg) && $stable(phase_reg)))
        else $error("parse state moved while result stalled");

    // every result leaves the parser idle with counters cleared
    a_result_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && fin) |=> (phase_reg == PH_IDLE && cnt_reg == 11'd0 && m_valid_reg))
        else $error("parser not cleared after result");

    // inside a segment there is always at least one segment still owed
    a_seg_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SEG) |-> (segs_left_reg != 8'd0 && segs_left_reg <= segs_total_reg))
        else $error("segment bookkeeping out of range");

endmodule

`default_nettype wire

// ===== verif/aml_name_string_checker.sv =====
// aml_name_string_checker: watches both channels of the name string parser, predicts each
// result from the accepted bytes and compares it field by field
// depends on amlns_pkg for the character codes and saturation limits
module aml_name_string_checker
    import amlns_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_parse_status,
    input  wire logic        m_rooted,
    input  wire logic [7:0]  m_parent_depth,
    input  wire logic [7:0]  m_segment_count,
    input  wire logic [8:0]  m_header_length,
    input  wire logic [10:0] m_total_length,
    output int               fail_count,
    output int               pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_PARENTS,
        NS_PATH,
        NS_COUNT,
        NS_SEG
    } ns_phase_t;

    typedef struct packed {
        logic        status;
        logic        rooted;
        logic [7:0]  depth;
        logic [7:0]  segs;
        logic [8:0]  hdr_len;
        logic [10:0] total_len;
    } name_result_t;

    name_result_t expected_names[$];

    ns_phase_t   ph;
    logic        root_q;
    logic [7:0]  depth_q;
    logic [7:0]  segs_q;
    logic [7:0]  segs_left_q;
    logic [1:0]  char_idx_q;
    logic [8:0]  hdr_q;
    logic [10:0] count_q;

    function automatic logic lead_char(input logic [7:0] b);
        return (b == "_") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic name_char(input logic [7:0] b);
        return (b >= "0" && b <= "9") || lead_char(b);
    endfunction

    task automatic clear_parser();
        ph          = NS_IDLE;
        root_q      = 1'b0;
        depth_q     = '0;
        segs_q      = '0;
        segs_left_q = '0;
        char_idx_q  = '0;
        hdr_q       = '0;
        count_q     = '0;
    endtask

    task automatic bump_header();
        if (hdr_q != HDR_MAX) begin
            hdr_q = hdr_q + 9'd1;
        end
    endtask

    task automatic emit_name(input logic status);
        name_result_t r;
        r.status    = status;
        r.rooted    = root_q;
        r.depth     = depth_q;
        r.segs      = segs_q;
        r.hdr_len   = hdr_q;
        r.total_len = count_q;
        expected_names.push_back(r);
        clear_parser();
    endtask

    // first byte of the path proper, after any root or parent prefix
    task automatic open_path(input logic [7:0] b);
        if (lead_char(b)) begin
            segs_q      = 8'd1;
            segs_left_q = 8'd1;
            char_idx_q  = 2'd1;
            ph          = NS_SEG;
        end else if (b == DUAL_PFX) begin
            bump_header();
            segs_q      = 8'd2;
            segs_left_q = 8'd2;
            char_idx_q  = 2'd0;
            ph          = NS_SEG;
        end else if (b == MULTI_PFX) begin
            bump_header();
            ph = NS_COUNT;
        end else if (b == NULL_NM) begin
            bump_header();
            emit_name(STATUS_OK);
        end else begin
            emit_name(STATUS_BAD);
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic ok;
        if (count_q != CNT_MAX) begin
            count_q = count_q + 11'd1;
        end
        case (ph)
            NS_IDLE: begin
                if (b == ROOT_CH) begin
                    root_q = 1'b1;
                    bump_header();
                    ph = NS_PATH;
                end else if (b == PARENT_CH) begin
                    depth_q = 8'd1;
                    bump_header();
                    ph = NS_PARENTS;
                end else begin
                    open_path(b);
                end
            end
            NS_PARENTS: begin
                if (b == PARENT_CH) begin
                    if (depth_q != DEPTH_MAX) begin
                        depth_q = depth_q + 8'd1;
                    end
                    bump_header();
                end else begin
                    open_path(b);
                end
            end
            NS_PATH: begin
                open_path(b);
            end
            NS_COUNT: begin
                bump_header();
                segs_q      = b;
                segs_left_q = b;
                char_idx_q  = 2'd0;
                if (b == 8'd0) begin
                    emit_name(STATUS_OK);
                end else begin
                    ph = NS_SEG;
                end
            end
            NS_SEG: begin
                ok = (char_idx_q == 2'd0) ? lead_char(b) : name_char(b);
                if (!ok) begin
                    emit_name(STATUS_BAD);
                end else if (char_idx_q == SEG_TAIL) begin
                    char_idx_q = 2'd0;
                    if (segs_left_q != 8'd0) begin
                        segs_left_q = segs_left_q - 8'd1;
                    end
                    if (segs_left_q == 8'd0) begin
                        emit_name(STATUS_OK);
                    end
                end else begin
                    char_idx_q = char_idx_q + 2'd1;
                end
            end
            default: begin
                clear_parser();
            end
        endcase
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // results are registered behind their byte, so comparing before predicting keeps order
    always @(posedge aclk) begin
        name_result_t exp_r;
        if (!aresetn) begin
            clear_parser();
            expected_names.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_names.size() == 0) begin
                    $error("result with no request waiting: status %0d, total length %0d",
                           m_parse_status, m_total_length);
                    fail_count++;
                end else begin
                    exp_r = expected_names.pop_front();
                    check_field("parse_status", exp_r.status, m_parse_status);
                    check_field("rooted", exp_r.rooted, m_rooted);
                    check_field("parent_depth", exp_r.depth, m_parent_depth);
                    check_field("segment_count", exp_r.segs, m_segment_count);
                    check_field("header_length", exp_r.hdr_len, m_header_length);
                    check_field("total_length", exp_r.total_len, m_total_length);
                end
            end
            if (s_valid && s_ready) begin
                parse_byte(s_data_byte);
            end
        end
        pending_results = expected_names.size();
    end

endmodule

// ===== verif/testbench.sv =====
// testbench: drives AML byte streams into aml_name_string_parser_core with random gaps and
// output stalls; aml_name_string_checker does the prediction and comparison
// depends on amlns_pkg and the two modules above
module testbench;
    import amlns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_BUDGET    = 1300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_parse_status;
    logic        m_rooted;
    logic [7:0]  m_parent_depth;
    logic [7:0]  m_segment_count;
    logic [8:0]  m_header_length;
    logic [10:0] m_total_length;

    int fail_count;
    int pending_results;
    int idle_cycles = 0;
    int ready_hold = 0;
    int calm_left = 0;

    logic [7:0] name_bytes[$];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    aml_name_string_parser_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_parse_status  (m_parse_status),
        .m_rooted        (m_rooted),
        .m_parent_depth  (m_parent_depth),
        .m_segment_count (m_segment_count),
        .m_header_length (m_header_length),
        .m_total_length  (m_total_length)
    );

    aml_name_string_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_parse_status  (m_parse_status),
        .m_rooted        (m_rooted),
        .m_parent_depth  (m_parent_depth),
        .m_segment_count (m_segment_count),
        .m_header_length (m_header_length),
        .m_total_length  (m_total_length),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [7:0] pick_lead();
        int r;
        r = $urandom_range(0, 26);
        return (r == 26) ? 8'h5F : 8'(8'h41 + r);
    endfunction

    function automatic logic [7:0] pick_namech();
        int r;
        r = $urandom_range(0, 36);
        if (r < 26) return 8'(8'h41 + r);
        if (r == 26) return 8'h5F;
        return 8'(8'h30 + r - 27);
    endfunction

    task automatic push_seg();
        name_bytes.push_back(pick_lead());
        repeat (3) name_bytes.push_back(pick_namech());
    endtask

    // output side: random stalls with quiet stretches where m_ready stays high
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
            calm_left  <= 0;
        end else begin
            if (calm_left > 0) begin
                calm_left <= calm_left - 1;
            end else if ($urandom_range(0, 199) == 0) begin
                calm_left <= $urandom_range(50, 300);
            end
            if (ready_hold > 0) begin
                m_ready    <= 1'b0;
                ready_hold <= ready_hold - 1;
            end else begin
                m_ready <= 1'b1;
                if (calm_left == 0 && $urandom_range(0, 2) == 0) begin
                    ready_hold <= gap_len();
                end
            end
        end
    end

    // count cycles in which neither channel moves a request
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input int gap);
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_name_bytes(input bit no_gaps);
        foreach (name_bytes[i]) begin
            send_byte(name_bytes[i], no_gaps ? 0 : gap_len());
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    task automatic build_random_string();
        int r;
        int n;
        int idx;
        name_bytes.delete();
        // pure noise
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) name_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        r = $urandom_range(0, 19);
        if (r >= 7 && r <= 12) begin
            name_bytes.push_back(ROOT_CH);
        end else if (r >= 13) begin
            n = (r == 19) ? $urandom_range(250, 262) : $urandom_range(1, 4);
            repeat (n) name_bytes.push_back(PARENT_CH);
        end
        r = $urandom_range(0, 9);
        if (r <= 3) begin
            push_seg();
        end else if (r <= 5) begin
            name_bytes.push_back(DUAL_PFX);
            push_seg();
            push_seg();
        end else if (r <= 8) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
            name_bytes.push_back(MULTI_PFX);
            name_bytes.push_back(8'(n));
            // large counts are cut short by a digit where a lead char belongs
            repeat ((n > 5) ? $urandom_range(0, 3) : n) push_seg();
            if (n > 5) name_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end else begin
            name_bytes.push_back(NULL_NM);
        end
        r = $urandom_range(0, 9);
        if (r < 2) begin
            idx = $urandom_range(0, name_bytes.size() - 1);
            name_bytes[idx] = 8'($urandom_range(0, 255));
        end else if (r == 2 && name_bytes.size() > 1) begin
            n = $urandom_range(1, name_bytes.size() - 1);
            while (name_bytes.size() > n) void'(name_bytes.pop_back());
        end
    endtask

    initial begin
        int sent;
        sent = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // null name, rooted seg, root after parents, parent after root, empty multi,
        // dual path, a byte that cannot start anything, plain seg
        name_bytes = '{NULL_NM, ROOT_CH, "_", "S", "B", "_", PARENT_CH, ROOT_CH,
                       ROOT_CH, PARENT_CH, MULTI_PFX, 8'h00, DUAL_PFX, "A", "0", "Z",
                       "9", "_", "_", "_", "_", 8'hFF, "Z", "9", "Q", "1"};
        sent += name_bytes.size();
        send_name_bytes(1'b0);
        drain_results();

        // parent run long enough to saturate depth
        name_bytes.delete();
        repeat (260) name_bytes.push_back(PARENT_CH);
        push_seg();
        sent += name_bytes.size();
        send_name_bytes(1'b0);

        // rooted multi path with the largest count, cut short by a digit
        name_bytes.delete();
        name_bytes.push_back(ROOT_CH);
        name_bytes.push_back(MULTI_PFX);
        name_bytes.push_back(8'hFF);
        repeat (2) push_seg();
        name_bytes.push_back("7");
        sent += name_bytes.size();
        send_name_bytes(1'b0);

        while (sent < ITEM_BUDGET) begin
            build_random_string();
            if ($urandom_range(0, 24) == 0) drain_results();
            sent += name_bytes.size();
            send_name_bytes($urandom_range(0, 3) == 0);
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
